@@ src/trt_pkg.sv @@
// Shared types and constants for the touch report tracker.
package trt_pkg;

  localparam int unsigned NumTracksDef = 10;
  localparam int unsigned TidW         = 5;
  localparam int unsigned HdrBytes     = 7;
  localparam int unsigned RecBytes     = 10;
  localparam logic [15:0] EmptyMark    = 16'hFF00;
  localparam logic [15:0] MinHdrLen    = 16'd6;
  localparam int unsigned IdPressBit   = 7;

  localparam logic [14:0] XExtentRst   = 15'd4095;
  localparam logic [14:0] YExtentRst   = 15'd4095;
  localparam logic [15:0] MaxBytesRst  = 16'd512;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_SHORT  = 2'd2,
    ERR_TRACK  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_MOVE = 2'd2,
    EV_UP   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    CFG_X_EXTENT  = 2'd0,
    CFG_Y_EXTENT  = 2'd1,
    CFG_MAX_BYTES = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    kind_e              kind;
    err_e               err;
    event_e             ev;
    logic [TidW-1:0]    tid;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        stamp;
    logic               last;
  } res_t;

  typedef struct packed {
    logic            upd;
    logic            press;
    logic [TidW-1:0] tid;
    logic [15:0]     x;
    logic [15:0]     y;
  } trk_req_t;

  typedef struct packed {
    logic        down;
    logic [15:0] x;
    logic [15:0] y;
  } trk_rsp_t;

endpackage

@@ src/trt_track.sv @@
// Per-track contact table: down flag and last reported point.
module trt_track import trt_pkg::*; #(
  parameter int unsigned NUM_TRACKS = NumTracksDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  trk_req_t req_i,
  output trk_rsp_t rsp_o
);

  localparam int unsigned TrkW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

  logic        down_q [NUM_TRACKS];
  logic [15:0] x_q    [NUM_TRACKS];
  logic [15:0] y_q    [NUM_TRACKS];
  logic [TrkW-1:0] sel;

  // The caller only asks for track numbers below NUM_TRACKS.
  assign sel = req_i.tid[TrkW-1:0];

  always_comb begin
    rsp_o.down = down_q[sel];
    rsp_o.x    = x_q[sel];
    rsp_o.y    = y_q[sel];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TRACKS; t++) begin
        down_q[t] <= 1'b0;
        x_q[t]    <= '1;
        y_q[t]    <= '1;
      end
    end else if (req_i.upd) begin
      down_q[sel] <= req_i.press;
      // A release leaves no stored point behind.
      x_q[sel]    <= req_i.press ? req_i.x : '1;
      y_q[sel]    <= req_i.press ? req_i.y : '1;
    end
  end

endmodule

@@ src/touch_report_tracker_top.sv @@
// Touch report parser and contact tracker, top level.
//
// The block takes one report byte per beat and gives at most one result per byte. Each byte
// is handled in the cycle it is accepted; its result goes to the output register, or to the
// skid entry if the output stalls, so the rate is one byte per clock cycle while in_stall_o
// is low. The two-entry output stage keeps taking bytes while a result waits; in_stall_o
// rises only when both entries hold results. The track table holds NUM_TRACKS entries in
// flip-flops and needs no clearing pass after reset. The user must write registers through
// the configuration channel only while no report is in flight; the block does not check it.
module touch_report_tracker_top import trt_pkg::*; #(
  parameter int unsigned NUM_TRACKS = NumTracksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  error_code_o,
  output logic [1:0]  event_code_o,
  output logic [4:0]  contact_tag_o,
  output logic signed [15:0] x_pos_o,
  output logic signed [15:0] y_pos_o,
  output logic [15:0] stamp_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [2:0] HdrDone = 3'(HdrBytes);
  localparam logic [3:0] RecLast = 4'(RecBytes - 1);

  // Configuration registers.
  logic [14:0] x_ext_q, y_ext_q;
  logic [15:0] max_len_q;

  // Parser state.
  logic [2:0]  hdr_q, hdr_d, e_hdr;
  logic [3:0]  off_q, off_d, e_off;
  logic [4:0]  k_q, k_d, e_k;
  logic [15:0] len_q, len_d, e_len, new_len;
  logic [4:0]  cnt_q, cnt_d, e_cnt;
  logic [15:0] stamp_q, stamp_d, e_stamp;
  logic        skip_q, skip_d, e_skip;
  logic [7:0]  rec_q [5];
  logic [9:0]  need_len;
  logic [5:0]  k_next;
  logic        rec_last;
  logic [15:0] mir_x, mir_y;

  logic     accept;
  logic     res_vld;
  res_t     res;
  trk_req_t trk_req;
  trk_rsp_t trk_rsp;

  // Output register and skid entry.
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_ext_q   <= XExtentRst;
      y_ext_q   <= YExtentRst;
      max_len_q <= MaxBytesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_X_EXTENT:  x_ext_q   <= cfg_data_i[14:0];
        CFG_Y_EXTENT:  y_ext_q   <= cfg_data_i[14:0];
        CFG_MAX_BYTES: max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A first byte restarts the report, dropping whatever was in progress.
  always_comb begin
    e_hdr   = first_byte_i ? 3'd0  : hdr_q;
    e_off   = first_byte_i ? 4'd0  : off_q;
    e_k     = first_byte_i ? 5'd0  : k_q;
    e_len   = first_byte_i ? 16'd0 : len_q;
    e_cnt   = first_byte_i ? 5'd0  : cnt_q;
    e_stamp = first_byte_i ? 16'd0 : stamp_q;
    e_skip  = first_byte_i ? 1'b0  : skip_q;
  end

  assign new_len  = {data_byte_i, e_len[7:0]};
  // Header plus ten bytes per contact, as shifts.
  assign need_len = 10'(HdrBytes) + {2'b00, data_byte_i[4:0], 3'b000}
                  + {4'b0000, data_byte_i[4:0], 1'b0};
  assign k_next   = {1'b0, e_k} + 6'd1;
  assign rec_last = (k_next >= {1'b0, e_cnt});
  assign mir_x    = {1'b0, x_ext_q} - {rec_q[2], rec_q[1]};
  assign mir_y    = {1'b0, y_ext_q} - {rec_q[4], rec_q[3]};

  always_comb begin
    hdr_d   = hdr_q;
    off_d   = off_q;
    k_d     = k_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    stamp_d = stamp_q;
    skip_d  = skip_q;
    res_vld = 1'b0;
    res     = '{kind: KIND_EVENT, err: ERR_NONE, ev: EV_NONE, tid: '0,
                x: '0, y: '0, stamp: e_stamp, last: 1'b0};
    trk_req = '{upd: 1'b0, press: 1'b0, tid: rec_q[0][TidW-1:0], x: mir_x, y: mir_y};

    if (accept) begin
      hdr_d   = e_hdr;
      off_d   = e_off;
      k_d     = e_k;
      len_d   = e_len;
      cnt_d   = e_cnt;
      stamp_d = e_stamp;
      skip_d  = e_skip;
      if (!e_skip) begin
        if (e_hdr != HdrDone) begin
          hdr_d = e_hdr + 3'd1;
          case (e_hdr)
            3'd0: len_d = {8'd0, data_byte_i};
            3'd1: begin
              len_d = new_len;
              if (new_len == 16'd0 || new_len == 16'd2 || new_len >= EmptyMark ||
                  new_len > max_len_q) begin
                skip_d   = 1'b1;
                res_vld  = 1'b1;
                res.kind = KIND_ERROR;
                res.err  = ERR_LENGTH;
                res.last = 1'b1;
              end else if (new_len < MinHdrLen) begin
                skip_d   = 1'b1;
                res_vld  = 1'b1;
                res.kind = KIND_ERROR;
                res.err  = ERR_SHORT;
                res.last = 1'b1;
              end
            end
            3'd3: stamp_d = {8'd0, data_byte_i};
            3'd4: stamp_d = {data_byte_i, e_stamp[7:0]};
            3'd5: begin
              cnt_d = data_byte_i[4:0];
              if (data_byte_i[4:0] == 5'd0) begin
                skip_d   = 1'b1;
                res_vld  = 1'b1;
                res.kind = KIND_EMPTY;
                res.last = 1'b1;
              end else if (e_len < {6'd0, need_len}) begin
                skip_d   = 1'b1;
                res_vld  = 1'b1;
                res.kind = KIND_ERROR;
                res.err  = ERR_SHORT;
                res.last = 1'b1;
              end
            end
            default: ;
          endcase
        end else if (e_off == RecLast) begin
          off_d    = 4'd0;
          k_d      = k_next[4:0];
          res_vld  = 1'b1;
          res.tid  = rec_q[0][TidW-1:0];
          res.last = rec_last;
          if (rec_last) begin
            skip_d = 1'b1;
          end
          if (32'(rec_q[0][TidW-1:0]) >= NUM_TRACKS) begin
            res.kind = KIND_ERROR;
            res.err  = ERR_TRACK;
          end else if (rec_q[0][IdPressBit]) begin
            trk_req.upd   = 1'b1;
            trk_req.press = 1'b1;
            res.ev = trk_rsp.down ? EV_MOVE : EV_DOWN;
            res.x  = mir_x;
            res.y  = mir_y;
          end else begin
            trk_req.upd = 1'b1;
            res.ev = trk_rsp.down ? EV_UP : EV_NONE;
            res.x  = trk_rsp.x;
            res.y  = trk_rsp.y;
          end
        end else begin
          off_d = e_off + 4'd1;
        end
      end
    end
  end

  trt_track #(
    .NUM_TRACKS(NUM_TRACKS)
  ) u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (trk_req),
    .rsp_o  (trk_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= '0;
      off_q   <= '0;
      k_q     <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      stamp_q <= '0;
      skip_q  <= 1'b1;
    end else begin
      hdr_q   <= hdr_d;
      off_q   <= off_d;
      k_q     <= k_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      stamp_q <= stamp_d;
      skip_q  <= skip_d;
    end
  end

  // Record bytes 1 to 5 hold the id and the raw point.
  always_ff @(posedge clk_i) begin
    if (accept && !e_skip && e_hdr == HdrDone && e_off >= 4'd1 && e_off <= 4'd5) begin
      rec_q[3'(e_off - 4'd1)] <= data_byte_i;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_vld;
      end
    end else if (res_vld) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_vld) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign error_code_o  = out_q.err;
  assign event_code_o  = out_q.ev;
  assign contact_tag_o = out_q.tid;
  assign x_pos_o       = out_q.x;
  assign y_pos_o       = out_q.y;
  assign stamp_o       = out_q.stamp;
  assign last_o        = out_q.last;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  a_error_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_ERROR) |->
      (out_q.ev == EV_NONE && out_q.x == 16'sd0 && out_q.y == 16'sd0 && out_q.err != ERR_NONE))
    else $error("error result carries an event or a point");

  a_rec_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q != HdrDone) |-> (off_q == 4'd0 && k_q == 5'd0))
    else $error("record counters moved before the header finished");

  a_skid_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && res_vld) |=> skid_valid_q)
    else $error("result lost while the output was stalled");
`endif

endmodule
